/* rtl/i2crrs_pkg.sv */
// i2crrs_pkg: types, codes and constants of the I2C register read sequencer.
// Used by every module of the block; depends on nothing.
package i2crrs_pkg;

   localparam int MAX_RESULTS         = 6;
   localparam int SLOT_W              = $clog2(MAX_RESULTS);
   localparam int COUNT_W             = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   typedef enum logic [1:0] {
      PH_START     = 2'd0,
      PH_REGSEND   = 2'd1,
      PH_RESTART   = 2'd2,
      PH_SLAVEDATA = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_START    = 3'd0,
      ACT_SEND     = 3'd1,
      ACT_ACK      = 3'd2,
      ACT_NACK     = 3'd3,
      ACT_STOP     = 3'd4,
      ACT_DONE     = 3'd5,
      ACT_BUS_STOP = 3'd6
   } action_type;

   typedef struct packed {
      logic       operation;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic       read_mode;
      logic       flag_ack;
      logic       flag_nack;
      logic       flag_rx;
      logic       flag_stop;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  tx_byte;
      logic [15:0] read_word;
      logic        last;
   } rsp_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  tx_byte;
      logic [15:0] read_word;
   } result_type;

   // All results caused by one transaction, oldest in slot 0.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [COUNT_W-1:0]           count;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic result_type make_result(action_type  action,
                                              logic [7:0]  tx_byte,
                                              logic [15:0] read_word);
      result_type r;
      r.action    = action;
      r.tx_byte   = tx_byte;
      r.read_word = read_word;
      return r;
   endfunction

endpackage

/* rtl/i2crrs_front.sv */
// i2crrs_front: takes transactions, tracks the bus phase and builds the result bundle.
// Depends on i2crrs_pkg.
module i2crrs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  i2crrs_pkg::req_type    item,
   output logic                   push,
   output i2crrs_pkg::bundle_type bundle
);
   import i2crrs_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        reading_ff, reading_in;
   logic [6:0]  slave_address_ff, slave_address_in;
   logic [7:0]  target_register_ff, target_register_in;
   logic        second_byte_due_ff, second_byte_due_in;
   logic [15:0] assembled_word_ff, assembled_word_in;

   phase_type   phase_ack, phase_nack;
   logic        is_event, ack_hit, nack_hit, rx_hit;
   logic [15:0] done_word;
   logic [COUNT_W-1:0] n;

   assign is_event  = (item.operation == OP_EVENT);
   assign ack_hit   = is_event && item.flag_ack && reading_ff;
   assign nack_hit  = is_event && item.flag_nack && reading_ff;
   assign done_word = assembled_word_ff | {8'h00, item.rx_byte};

   // Next state: ACK walks the phases, then NACK may pull back to start.
   always_comb begin
      phase_ack = phase_ff;
      if (ack_hit) begin
         unique case (phase_ff)
            PH_START:                  phase_ack = PH_REGSEND;
            PH_REGSEND:                phase_ack = PH_RESTART;
            PH_RESTART, PH_SLAVEDATA:  phase_ack = PH_SLAVEDATA;
         endcase
      end
      phase_nack = phase_ack;
      if (nack_hit && phase_ack != PH_RESTART) begin
         phase_nack = PH_START;
      end
      rx_hit = is_event && item.flag_rx && (phase_nack == PH_SLAVEDATA);

      phase_in           = phase_ff;
      reading_in         = reading_ff;
      slave_address_in   = slave_address_ff;
      target_register_in = target_register_ff;
      second_byte_due_in = second_byte_due_ff;
      assembled_word_in  = assembled_word_ff;
      if (accept) begin
         if (!is_event) begin
            slave_address_in   = item.device_address;
            target_register_in = item.register_address;
            reading_in         = item.read_mode;
            phase_in           = PH_START;
         end else begin
            phase_in = phase_nack;
            if (rx_hit) begin
               if (second_byte_due_ff) begin
                  second_byte_due_in = 1'b0;
                  assembled_word_in  = done_word;
               end else begin
                  second_byte_due_in = 1'b1;
                  assembled_word_in  = {item.rx_byte, 8'h00};
               end
            end
         end
      end
   end

   // Outputs: a start transaction yields one START; an event appends results in order ACK, NACK, RX, STOP.
   always_comb begin
      bundle = '0;
      n      = '0;
      if (!is_event) begin
         bundle.slot[SLOT_W'(n)] = make_result(ACT_START, {item.device_address, RW_WRITE}, '0);
         n = n + 1'b1;
      end else begin
         if (ack_hit) begin
            unique case (phase_ff)
               PH_START: begin
                  bundle.slot[SLOT_W'(n)] = make_result(ACT_SEND, target_register_ff, '0);
                  n = n + 1'b1;
               end
               PH_REGSEND: begin
                  bundle.slot[SLOT_W'(n)] =
                     make_result(ACT_START, {slave_address_ff, RW_READ}, '0);
                  n = n + 1'b1;
               end
               PH_RESTART, PH_SLAVEDATA: begin
               end
            endcase
         end
         if (nack_hit) begin
            if (phase_ack == PH_RESTART) begin
               bundle.slot[SLOT_W'(n)] =
                  make_result(ACT_START, {slave_address_ff, RW_READ}, '0);
            end else begin
               bundle.slot[SLOT_W'(n)] =
                  make_result(ACT_START, {slave_address_ff, RW_WRITE}, '0);
            end
            n = n + 1'b1;
         end
         if (rx_hit) begin
            if (second_byte_due_ff) begin
               bundle.slot[SLOT_W'(n)] = make_result(ACT_NACK, '0, '0);
               n = n + 1'b1;
               bundle.slot[SLOT_W'(n)] = make_result(ACT_STOP, '0, '0);
               n = n + 1'b1;
               bundle.slot[SLOT_W'(n)] = make_result(ACT_DONE, '0, done_word);
               n = n + 1'b1;
            end else begin
               bundle.slot[SLOT_W'(n)] = make_result(ACT_ACK, '0, '0);
               n = n + 1'b1;
            end
         end
         if (item.flag_stop) begin
            bundle.slot[SLOT_W'(n)] = make_result(ACT_BUS_STOP, '0, '0);
            n = n + 1'b1;
         end
      end
      bundle.count = n;
      push         = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_START;
         reading_ff         <= 1'b0;
         slave_address_ff   <= '0;
         target_register_ff <= '0;
         second_byte_due_ff <= 1'b0;
         assembled_word_ff  <= '0;
      end else begin
         phase_ff           <= phase_in;
         reading_ff         <= reading_in;
         slave_address_ff   <= slave_address_in;
         target_register_ff <= target_register_in;
         second_byte_due_ff <= second_byte_due_in;
         assembled_word_ff  <= assembled_word_in;
      end
   end

endmodule

/* rtl/i2crrs_queue.sv */
// i2crrs_queue: short queue of result bundles between the front and back parts.
// Depends on i2crrs_pkg.
module i2crrs_queue #(
   parameter int DEPTH = i2crrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  i2crrs_pkg::bundle_type       push_bundle,
   input  logic                         pop,
   output i2crrs_pkg::bundle_type       head,
   output i2crrs_pkg::queue_status_type status
);
   import i2crrs_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) r = '0;
      else                        r = p + 1'b1;
      return r;
   endfunction

   assign head         = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("bundle pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

endmodule

/* rtl/i2crrs_back.sv */
// i2crrs_back: unpacks queued bundles one result per cycle, while the output is taken, into the output register.
// Depends on i2crrs_pkg.
module i2crrs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  i2crrs_pkg::bundle_type       head,
   input  i2crrs_pkg::queue_status_type q_status,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output i2crrs_pkg::rsp_type          rsp_payload
);
   import i2crrs_pkg::*;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              taken, advance, last_slot;
   result_type        cur;

   assign taken     = rsp_pop && rsp_valid_ff;
   assign advance   = !q_status.empty && (!rsp_valid_ff || taken);
   assign cur       = head.slot[idx_ff];
   assign last_slot = (COUNT_W'(idx_ff) + COUNT_W'(1)) == head.count;
   assign q_pop     = advance && last_slot;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in      = 1'b1;
         rsp_in.action     = cur.action;
         rsp_in.tx_byte    = cur.tx_byte;
         rsp_in.read_word  = cur.read_word;
         rsp_in.last       = last_slot;
         idx_in            = last_slot ? '0 : idx_ff + 1'b1;
      end else if (taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("bundle retired from an empty queue");

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (COUNT_W'(idx_ff) < head.count))
      else $error("slot index past the bundle's result count");

   a_idx_steps: assert property (@(posedge clock) disable iff (reset)
      (advance && !last_slot) |=> (idx_ff != '0))
      else $error("slot index did not advance inside a bundle");

endmodule

/* rtl/i2c_register_read_sequencer.sv */
// i2c_register_read_sequencer: top level of the I2C 16-bit register read sequencer.
// Depends on i2crrs_pkg, i2crrs_front, i2crrs_queue and i2crrs_back.
//
// Usage
//   Request side (req_): a queue write port. A transaction is taken at a rising
//   edge with req_push high and req_full low. A start transaction latches the
//   slave address, register address and read mode; an event transaction carries
//   the ACK, NACK, RX and STOP flags plus a received byte.
//   Response side (rsp_): a queue read port. While rsp_empty is low the oldest
//   bus action sits on rsp_payload; it is taken at an edge with rsp_pop high.
//   The last action caused by a request carries last = 1. An event with no
//   effect produces no action at all.
//   Path: the first action of a request is written into the bundle queue and then
//   loaded into the output register; further actions of the same request follow.
//   Throughput: one action per cycle while the receiver keeps taking them; a request
//   causes one to four actions, all delivered through the single output register
//   that drains the bundle queue. Requests are taken back to back until the bundle
//   queue (QUEUE_DEPTH entries) fills.
//   Reset: synchronous; clears the bus phase, latched addresses, byte assembly
//   and all queues. When the receiver stalls, the held action stays put, the
//   queue fills, and req_full rises to hold off the sender.
module i2c_register_read_sequencer #(
   parameter int QUEUE_DEPTH = i2crrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  i2crrs_pkg::req_type req_payload,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output i2crrs_pkg::rsp_type rsp_payload
);
   import i2crrs_pkg::*;

   logic             accept;
   logic             push;
   logic             q_pop;
   bundle_type       push_bundle;
   bundle_type       head;
   queue_status_type q_status;

   // Hold off the sender only when there is no room for another bundle.
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   // Front: update the bus phase and build all actions of one transaction.
   i2crrs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_payload),
      .push   (push),
      .bundle (push_bundle)
   );

   // Decouple transaction intake from action delivery.
   i2crrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (q_pop),
      .head        (head),
      .status      (q_status)
   );

   // Back: advance through the head bundle, one action per cycle while the receiver takes them.
   i2crrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule
